// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, switched off while reset is active.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
	else $error("assertion failed");

// Concurrent assertion sampled on the rising clock edge, checked in reset too.
`define ASSERT_CLK(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
	else $error("assertion failed");

`endif

// File: rtl/ted_pkg.sv
// Types, constants and helper functions for the text encoding detector.
`timescale 1ns / 1ps

package ted_pkg;

	// Limit on the next UTF-8 continuation byte after a lead byte.
	typedef enum logic [2:0] {
		RNG_80_BF = 3'd0,
		RNG_A0_BF = 3'd1,
		RNG_80_9F = 3'd2,
		RNG_90_BF = 3'd3,
		RNG_80_8F = 3'd4
	} utf8_range_t;

	// Bit positions in the result mask.
	localparam int unsigned MaskUtf8Bit  = 0;
	localparam int unsigned MaskUtf16Bit = 1;
	localparam int unsigned MaskUtf32Bit = 2;
	localparam int unsigned MaskWidth    = 3;
	localparam int unsigned TdataWidth   = 8;

	// True when a continuation byte lies inside the window the lead byte allows.
	function automatic logic utf8_cont_ok(input logic [7:0] b, input utf8_range_t rng);
		logic ok;
		begin
			case (rng)
				RNG_A0_BF: ok = (b >= 8'hA0) && (b <= 8'hBF);
				RNG_80_9F: ok = (b >= 8'h80) && (b <= 8'h9F);
				RNG_90_BF: ok = (b >= 8'h90) && (b <= 8'hBF);
				RNG_80_8F: ok = (b >= 8'h80) && (b <= 8'h8F);
				default:   ok = (b >= 8'h80) && (b <= 8'hBF);
			endcase
			return ok;
		end
	endfunction

	// High byte of a UTF-16 word that is a high (leading) surrogate.
	function automatic logic is_high_surr(input logic [7:0] hi_byte);
		return hi_byte[7:2] == 6'b110110;
	endfunction

	// High byte of a UTF-16 word that is a low (trailing) surrogate.
	function automatic logic is_low_surr(input logic [7:0] hi_byte);
		return hi_byte[7:2] == 6'b110111;
	endfunction

endpackage

// File: rtl/text_encoding_detector.sv
// Top level of the text encoding detector: UTF-8, UTF-16LE and UTF-32LE checks on a byte stream.
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata[7:0] = data_byte, tlast = last_byte
// m_axis    out        tdata[2:0] = valid_encodings, tdata[7:3] = 0
//
// One byte is taken per clock while s_axis_tready is high. Every check updates its state
// in the same cycle the byte transfer happens, and the result of a buffer is in the output
// register in the cycle after its last byte. The output register is the only stall point:
// s_axis_tready drops only while a result sits unread and m_axis_tready is low.
// arst_n clears all checker state and empties the output register.
// After each last byte every checker returns to its reset state for the next buffer.
module text_encoding_detector
	import ted_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [TdataWidth-1:0] s_axis_tdata,   // [7:0] data_byte
	input  logic                  s_axis_tlast,   // last_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [TdataWidth-1:0] m_axis_tdata    // [2:0] valid_encodings, [7:3] zero
);

	// Checker state.
	logic                 utf8_ok_q;
	logic [1:0]           utf8_pend_q;
	utf8_range_t          utf8_rng_q;
	logic                 utf16_ok_q;
	logic                 utf16_hi_pend_q;
	logic                 utf32_ok_q;
	logic [23:0]          word_part_q;
	logic [1:0]           phase_q;

	// Output register.
	logic                 res_valid_q;
	logic [MaskWidth-1:0] res_mask_q;

	// Next-state values computed from the incoming byte.
	logic                 utf8_ok_d;
	logic [1:0]           utf8_pend_d;
	utf8_range_t          utf8_rng_d;
	logic                 utf16_ok_d;
	logic                 utf16_hi_pend_d;
	logic                 utf32_ok_d;
	logic [23:0]          word_part_d;
	logic [MaskWidth-1:0] mask_d;
	logic [7:0]           b;
	logic                 in_xfer;
	logic                 w16_done;
	logic                 w32_bad;

	assign b       = s_axis_tdata[7:0];
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// A new byte is welcome unless a result is stuck in the output register.
	assign s_axis_tready = !res_valid_q || m_axis_tready;

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {{(TdataWidth - MaskWidth){1'b0}}, res_mask_q};

	always_comb begin
		// UTF-8: either a continuation byte inside a sequence, or a new lead byte.
		utf8_ok_d   = utf8_ok_q;
		utf8_pend_d = utf8_pend_q;
		utf8_rng_d  = RNG_80_BF;
		if (utf8_pend_q != 2'd0) begin
			if (utf8_cont_ok(b, utf8_rng_q)) begin
				utf8_pend_d = utf8_pend_q - 2'd1;
			end else begin
				// Error: the sequence is dropped so later bytes parse as new leads.
				utf8_ok_d   = 1'b0;
				utf8_pend_d = 2'd0;
			end
		end else begin
			case (b) inside
				[8'h00:8'h7F]: utf8_pend_d = 2'd0;
				[8'hC2:8'hDF]: utf8_pend_d = 2'd1;
				[8'hE0:8'hEF]: begin
					utf8_pend_d = 2'd2;
					// E0 would allow overlong forms, ED would encode surrogates.
					if (b == 8'hE0) begin
						utf8_rng_d = RNG_A0_BF;
					end else if (b == 8'hED) begin
						utf8_rng_d = RNG_80_9F;
					end
				end
				[8'hF0:8'hF4]: begin
					utf8_pend_d = 2'd3;
					// F0 would allow overlong forms, F4 values above the code space.
					if (b == 8'hF0) begin
						utf8_rng_d = RNG_90_BF;
					end else if (b == 8'hF4) begin
						utf8_rng_d = RNG_80_8F;
					end
				end
				default: utf8_ok_d = 1'b0;
			endcase
		end

		// UTF-16LE: a word completes on odd phases; only its high byte decides the class.
		w16_done = phase_q[0];
		utf16_ok_d      = utf16_ok_q;
		utf16_hi_pend_d = utf16_hi_pend_q;
		if (w16_done) begin
			if (utf16_hi_pend_q) begin
				if (!is_low_surr(b)) begin
					utf16_ok_d = 1'b0;
				end
				utf16_hi_pend_d = 1'b0;
			end else if (is_high_surr(b)) begin
				utf16_hi_pend_d = 1'b1;
			end else if (is_low_surr(b)) begin
				utf16_ok_d = 1'b0;
			end
		end

		// UTF-32LE: on the fourth byte, reject values above 10FFFF and surrogates.
		w32_bad = (b != 8'h00) || (word_part_q[23:16] > 8'h10)
			|| ((word_part_q[23:16] == 8'h00) && (word_part_q[15:11] == 5'b11011));
		utf32_ok_d = utf32_ok_q;
		if (phase_q == 2'd3 && w32_bad) begin
			utf32_ok_d = 1'b0;
		end

		// Collect the bytes of the current 32-bit word.
		word_part_d = word_part_q;
		case (phase_q)
			2'd0:    word_part_d[7:0]   = b;
			2'd1:    word_part_d[15:8]  = b;
			2'd2:    word_part_d[23:16] = b;
			default: word_part_d        = 24'h0;
		endcase

		// Result mask for a buffer that ends on this byte.
		mask_d = '0;
		mask_d[MaskUtf8Bit]  = utf8_ok_d && (utf8_pend_d == 2'd0);
		mask_d[MaskUtf16Bit] = utf16_ok_d && !utf16_hi_pend_d && phase_q[0];
		mask_d[MaskUtf32Bit] = utf32_ok_d && (phase_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_ok_q       <= 1'b1;
			utf8_pend_q     <= 2'd0;
			utf8_rng_q      <= RNG_80_BF;
			utf16_ok_q      <= 1'b1;
			utf16_hi_pend_q <= 1'b0;
			utf32_ok_q      <= 1'b1;
			word_part_q     <= 24'h0;
			phase_q         <= 2'd0;
		end else if (in_xfer) begin
			if (s_axis_tlast) begin
				// End of buffer: start the next one from a clean slate.
				utf8_ok_q       <= 1'b1;
				utf8_pend_q     <= 2'd0;
				utf8_rng_q      <= RNG_80_BF;
				utf16_ok_q      <= 1'b1;
				utf16_hi_pend_q <= 1'b0;
				utf32_ok_q      <= 1'b1;
				word_part_q     <= 24'h0;
				phase_q         <= 2'd0;
			end else begin
				utf8_ok_q       <= utf8_ok_d;
				utf8_pend_q     <= utf8_pend_d;
				utf8_rng_q      <= utf8_rng_d;
				utf16_ok_q      <= utf16_ok_d;
				utf16_hi_pend_q <= utf16_hi_pend_d;
				utf32_ok_q      <= utf32_ok_d;
				word_part_q     <= word_part_d;
				phase_q         <= phase_q + 2'd1;
			end
		end
	end

	// Output register: loaded by a last byte, emptied when the consumer takes the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_xfer && s_axis_tlast) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && s_axis_tlast) begin
			res_mask_q <= mask_d;
		end
	end

endmodule

// File: rtl/ted_checker.sv
// Port-level checker for the text encoding detector and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ted_checker
	import ted_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  s_axis_tlast,   // last_byte
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [TdataWidth-1:0] m_axis_tdata    // [2:0] valid_encodings, [7:3] zero
);

	logic in_last_xfer;
	assign in_last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;

	// A stalled result keeps its value.
	`ASSERT_CLKD(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

	// The last byte of a buffer always yields a result in the next cycle.
	`ASSERT_CLKD(a_last_gives_result, clk, arst_n, in_last_xfer |=> m_axis_tvalid)

	// A result only appears after a last byte was taken.
	`ASSERT_CLKD(a_no_spurious_result, clk, arst_n, $rose(m_axis_tvalid) |-> $past(in_last_xfer))

	// Input backpressure comes only from an unread result.
	`ASSERT_CLKD(a_ready_only_on_stall, clk, arst_n, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)

	// The padding above the mask stays zero.
	`ASSERT_CLKD(a_pad_zero, clk, arst_n, m_axis_tvalid |-> m_axis_tdata[TdataWidth-1:MaskWidth] == '0)

endmodule

bind text_encoding_detector ted_checker u_ted_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: bench/encoding_mask_checker.sv
// Checker that predicts the encoding mask of each buffer and compares it with the block output.
`timescale 1ns / 1ps

module encoding_mask_checker
	import ted_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [TdataWidth-1:0] s_axis_tdata,   // [7:0] data_byte
	input  logic                  s_axis_tlast,   // last_byte
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [TdataWidth-1:0] m_axis_tdata,   // [2:0] valid_encodings, [7:3] zero
	output int unsigned           mask_mismatches,
	output int unsigned           masks_outstanding
);

	// Running state of the three encoding checks for the buffer in flight.
	logic             u8_ok;
	logic [1:0]       u8_left;
	utf8_range_t      u8_window;
	logic             u16_ok;
	logic             u16_high;
	logic             u32_ok;
	logic [23:0]      word_bytes;
	logic [1:0]       word_phase;

	logic [MaskWidth-1:0] expected_masks[$];
	logic [MaskWidth-1:0] want_mask;

	task automatic clear_tracking();
		u8_ok      = 1'b1;
		u8_left    = 2'd0;
		u8_window  = RNG_80_BF;
		u16_ok     = 1'b1;
		u16_high   = 1'b0;
		u32_ok     = 1'b1;
		word_bytes = '0;
		word_phase = 2'd0;
	endtask

	task automatic log_mismatch(input string why, input logic [TdataWidth-1:0] want,
			input logic [TdataWidth-1:0] got);
		if (mask_mismatches < 10)
			$display("%0t mismatch (%s): expected mask %b, got tdata %b", $realtime, why, want, got);
		mask_mismatches++;
	endtask

	task automatic take_utf8_byte(input logic [7:0] b);
		logic [7:0] lo_lim;
		logic [7:0] hi_lim;
		lo_lim = 8'h80;
		hi_lim = 8'hBF;
		if (u8_left != 2'd0) begin
			case (u8_window)
				RNG_A0_BF: lo_lim = 8'hA0;
				RNG_80_9F: hi_lim = 8'h9F;
				RNG_90_BF: lo_lim = 8'h90;
				RNG_80_8F: hi_lim = 8'h8F;
				default: ;
			endcase
			// A bad continuation kills UTF-8 and restarts parsing at the next byte.
			if (b < lo_lim || b > hi_lim) begin
				u8_ok   = 1'b0;
				u8_left = 2'd0;
			end else begin
				u8_left = u8_left - 2'd1;
			end
			u8_window = RNG_80_BF;
		end else begin
			u8_window = RNG_80_BF;
			if (b >= 8'hC2 && b <= 8'hDF) begin
				u8_left = 2'd1;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				u8_left = 2'd2;
				if (b == 8'hE0)
					u8_window = RNG_A0_BF;
				else if (b == 8'hED)
					u8_window = RNG_80_9F;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				u8_left = 2'd3;
				if (b == 8'hF0)
					u8_window = RNG_90_BF;
				else if (b == 8'hF4)
					u8_window = RNG_80_8F;
			end else if (b[7]) begin
				u8_ok = 1'b0;
			end
		end
	endtask

	task automatic take_utf16_unit(input logic [15:0] unit);
		logic hi_half;
		logic lo_half;
		hi_half = unit[15:10] == 6'b110110;
		lo_half = unit[15:10] == 6'b110111;
		if (u16_high) begin
			if (!lo_half)
				u16_ok = 1'b0;
			u16_high = 1'b0;
		end else if (hi_half) begin
			u16_high = 1'b1;
		end else if (lo_half) begin
			u16_ok = 1'b0;
		end
	endtask

	task automatic track_byte(input logic [7:0] b, input logic last);
		logic [1:0]           ph;
		logic [31:0]          w32;
		logic [MaskWidth-1:0] mask;
		ph = word_phase;
		take_utf8_byte(b);
		if (ph == 2'd1) begin
			take_utf16_unit({b, word_bytes[7:0]});
		end else if (ph == 2'd3) begin
			take_utf16_unit({b, word_bytes[23:16]});
			w32 = {b, word_bytes};
			if (w32 > 32'h0010_FFFF || (w32 >= 32'hD800 && w32 <= 32'hDFFF))
				u32_ok = 1'b0;
		end
		if (ph == 2'd3)
			word_bytes = '0;
		else
			word_bytes = word_bytes | (24'(b) << (8 * ph));
		word_phase = ph + 2'd1;
		if (last) begin
			mask = '0;
			mask[MaskUtf8Bit]  = u8_ok && (u8_left == 2'd0);
			mask[MaskUtf16Bit] = u16_ok && !u16_high && ph[0];
			mask[MaskUtf32Bit] = u32_ok && (ph == 2'd3);
			expected_masks.push_back(mask);
			clear_tracking();
		end
	endtask

	// The output side is handled first: a result leaving now always belongs to an older byte.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_tracking();
			expected_masks.delete();
			mask_mismatches   = 0;
			masks_outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_masks.size() == 0) begin
					log_mismatch("no result due", '0, m_axis_tdata);
				end else begin
					want_mask = expected_masks.pop_front();
					if (m_axis_tdata !== TdataWidth'(want_mask))
						log_mismatch("wrong mask", TdataWidth'(want_mask), m_axis_tdata);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				track_byte(s_axis_tdata, s_axis_tlast);
			masks_outstanding = expected_masks.size();
		end
	end

endmodule

// File: bench/tb_top.sv
// Top of the bench: clock, reset, byte buffer stimulus, result sink and the final verdict.
`timescale 1ns / 1ps

module tb_top
	import ted_pkg::*;
();

	// Longest stretch without any transfer before the run is declared hung. It is set well above
	// the long receiver hold-off, so this leaves plenty of margin.
	localparam int QuietLimit = 2000;
	localparam int HoldOffCycles = 300;

	// Flavors of generated buffers. Most are well-formed text with random content, so
	// the deeper states of each checker are reached; the rest is noise.
	typedef enum int {
		TXT_UTF8,
		TXT_UTF16,
		TXT_UTF32,
		TXT_NOISE
	} text_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [TdataWidth-1:0] s_axis_tdata;   // [7:0] data_byte
	logic                  s_axis_tlast;   // last_byte
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [TdataWidth-1:0] m_axis_tdata;   // [2:0] valid_encodings, [7:3] zero

	int unsigned mask_mismatches;
	int unsigned masks_outstanding;

	// Knobs shared between the sender, the receiver and the phase sequencer.
	int          sender_idle_pct;
	int          receiver_stall_pct;
	bit          hold_request;
	int unsigned bytes_sent;
	int unsigned quiet_cycles;

	// The buffer that is about to be sent, in memory order.
	logic [7:0] text_bytes[$];

	text_encoding_detector DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	encoding_mask_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_axis_tvalid     (s_axis_tvalid),
		.s_axis_tready     (s_axis_tready),
		.s_axis_tdata      (s_axis_tdata),
		.s_axis_tlast      (s_axis_tlast),
		.m_axis_tvalid     (m_axis_tvalid),
		.m_axis_tready     (m_axis_tready),
		.m_axis_tdata      (m_axis_tdata),
		.mask_mismatches   (mask_mismatches),
		.masks_outstanding (masks_outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: counts cycles in which neither channel completes a transfer.
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Result sink. Every falling edge it decides whether to accept this cycle. A hold-off
	// request from the sequencer keeps tready low for a counted stretch so that the output
	// register fills and the block pushes back on its input.
	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HoldOffCycles;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				m_axis_tready = ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// One byte transfer. Inputs change on the falling edge; the handshake is judged on
	// the rising edge. While idle, tdata carries junk so that it is seen to be ignored.
	task automatic send_transfer(input logic [7:0] b, input logic last);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = 8'($urandom);
			s_axis_tlast  = 1'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = b;
		s_axis_tlast  = last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_text_buffer();
		int n;
		n = text_bytes.size();
		for (int i = 0; i < n; i++)
			send_transfer(text_bytes[i], i == n - 1);
	endtask

	// Code points spread over every UTF-8 length class, with the range edges often.
	function automatic logic [31:0] pick_code_point();
		case ($urandom_range(5))
			0: return $urandom_range(32'h7F, 32'h0);
			1: return $urandom_range(32'h7FF, 32'h80);
			2: return $urandom_range(32'hD7FF, 32'h800);
			3: return $urandom_range(32'hFFFF, 32'hE000);
			4: return $urandom_range(32'h10_FFFF, 32'h1_0000);
			default: begin
				case ($urandom_range(9))
					0: return 32'h0;
					1: return 32'h7F;
					2: return 32'h80;
					3: return 32'h7FF;
					4: return 32'h800;
					5: return 32'hD7FF;
					6: return 32'hE000;
					7: return 32'hFFFF;
					8: return 32'h1_0000;
					default: return 32'h10_FFFF;
				endcase
			end
		endcase
	endfunction

	task automatic push_utf8(input logic [31:0] cp);
		if (cp < 32'h80) begin
			text_bytes.push_back(cp[7:0]);
		end else if (cp < 32'h800) begin
			text_bytes.push_back({3'b110, cp[10:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end else if (cp < 32'h1_0000) begin
			text_bytes.push_back({4'b1110, cp[15:12]});
			text_bytes.push_back({2'b10, cp[11:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end else begin
			text_bytes.push_back({5'b11110, cp[20:18]});
			text_bytes.push_back({2'b10, cp[17:12]});
			text_bytes.push_back({2'b10, cp[11:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end
	endtask

	task automatic push_utf16_unit(input logic [15:0] unit);
		text_bytes.push_back(unit[7:0]);
		text_bytes.push_back(unit[15:8]);
	endtask

	task automatic build_buffer();
		text_kind_t  kind;
		int          chars;
		int          roll;
		int          idx;
		logic [31:0] cp;
		text_bytes.delete();
		chars = $urandom_range(6, 1);
		roll  = $urandom_range(99);
		kind  = (roll < 40) ? TXT_UTF8 : (roll < 65) ? TXT_UTF16 : (roll < 85) ? TXT_UTF32 :
			TXT_NOISE;
		for (int c = 0; c < chars; c++) begin
			case (kind)
				TXT_UTF8: begin
					if ($urandom_range(9) == 0) begin
						// A lead byte at a range edge followed by arbitrary continuations:
						// this is where overlong forms and encoded surrogates show up.
						case ($urandom_range(8))
							0: text_bytes.push_back(8'hC0);
							1: text_bytes.push_back(8'hC1);
							2: text_bytes.push_back(8'hC2);
							3: text_bytes.push_back(8'hDF);
							4: text_bytes.push_back(8'hE0);
							5: text_bytes.push_back(8'hED);
							6: text_bytes.push_back(8'hF0);
							7: text_bytes.push_back(8'hF4);
							default: text_bytes.push_back(8'hF5);
						endcase
						repeat ($urandom_range(3, 1))
							text_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
					end else begin
						push_utf8(pick_code_point());
					end
				end
				TXT_UTF16: begin
					cp = pick_code_point();
					if ($urandom_range(9) == 0) begin
						// Lone surrogate half, high or low.
						push_utf16_unit(16'($urandom_range(16'hDFFF, 16'hD800)));
					end else if (cp < 32'h1_0000) begin
						push_utf16_unit(cp[15:0]);
					end else begin
						cp = cp - 32'h1_0000;
						push_utf16_unit({6'b110110, cp[19:10]});
						push_utf16_unit({6'b110111, cp[9:0]});
					end
				end
				TXT_UTF32: begin
					case ($urandom_range(9))
						0: cp = $urandom_range(32'hDFFF, 32'hD800);
						1: cp = $urandom_range(32'hFFFF_FFFF, 32'h11_0000);
						2: cp = 32'h11_0000;
						default: cp = pick_code_point();
					endcase
					for (int k = 0; k < 4; k++)
						text_bytes.push_back(cp[8*k +: 8]);
				end
				default: begin
					text_bytes.push_back(8'($urandom));
				end
			endcase
		end
		// Occasional damage: a flipped bit, a lost final byte, or a stray extra byte.
		roll = $urandom_range(99);
		if (roll < 8) begin
			idx = $urandom_range(text_bytes.size() - 1);
			text_bytes[idx] = text_bytes[idx] ^ (8'h01 << $urandom_range(7));
		end else if (roll < 14 && text_bytes.size() > 1) begin
			void'(text_bytes.pop_back());
		end else if (roll < 18) begin
			text_bytes.push_back(8'($urandom));
		end
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct,
			input int unsigned count);
		int unsigned stop_at;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			build_buffer();
			send_text_buffer();
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		s_axis_tvalid      = 1'b0;
		s_axis_tdata       = '0;
		s_axis_tlast       = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_request       = 1'b0;
		bytes_sent         = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed buffers: byte extremes, one-byte buffers, a UTF-32 word just past the
		// top, the top itself, a surrogate pair, a three-byte sequence with a restricted
		// second byte, an encoded surrogate followed by a truncated lead, an unpaired high
		// surrogate at the end, and a four-byte lead past the top of the code space.
		text_bytes = '{8'h00};
		send_text_buffer();
		text_bytes = '{8'hFF};
		send_text_buffer();
		text_bytes = '{8'h00, 8'h00, 8'h11, 8'h00};
		send_text_buffer();
		text_bytes = '{8'hFF, 8'hFF, 8'h10, 8'h00};
		send_text_buffer();
		text_bytes = '{8'h3D, 8'hD8, 8'h00, 8'hDE};
		send_text_buffer();
		text_bytes = '{8'hE0, 8'hA0, 8'h80};
		send_text_buffer();
		text_bytes = '{8'hED, 8'hA0, 8'h80, 8'hC3};
		send_text_buffer();
		text_bytes = '{8'h00, 8'hD8};
		send_text_buffer();
		text_bytes = '{8'hF4, 8'h90};
		send_text_buffer();

		// Random traffic under each idling pattern in turn.
		run_random_phase(0, 0, 430);
		run_random_phase(65, 0, 430);
		run_random_phase(0, 65, 430);

		// Back-pressure: the sink holds off for a long stretch while short buffers keep
		// coming, so the output register fills and the input stalls.
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_request       = 1'b1;
		repeat (40) begin
			text_bytes.delete();
			repeat ($urandom_range(2, 1))
				text_bytes.push_back(8'($urandom));
			send_text_buffer();
		end

		// The sender rests until every result is out, then traffic resumes.
		s_axis_tvalid = 1'b0;
		wait (masks_outstanding == 0);
		@(negedge clk);

		run_random_phase(18, 18, 430);

		s_axis_tvalid = 1'b0;
		wait (masks_outstanding == 0);
		repeat (8) @(posedge clk);
		if (mask_mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ted_pkg.sv
rtl/text_encoding_detector.sv
rtl/ted_checker.sv
bench/encoding_mask_checker.sv
bench/tb_top.sv
